[hw/rtl/tpr_pkg.sv]
// touch press/release debouncer: shared types, constants and register codes
// used by every module and interface of the block; depends on nothing
`default_nettype none

package tpr_pkg;

  localparam int COORD_W    = 12;
  localparam int TIMER_W    = 10;
  localparam int ROT_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int PROD_W     = 2 * COORD_W;

  // calibration window
  localparam logic [COORD_W-1:0] CAL_X_LO = COORD_W'(220);
  localparam logic [COORD_W-1:0] CAL_X_HI = COORD_W'(3900);
  localparam logic [COORD_W-1:0] CAL_Y_LO = COORD_W'(140);
  localparam logic [COORD_W-1:0] CAL_Y_HI = COORD_W'(3750);
  localparam logic [COORD_W-1:0] SPAN_X   = CAL_X_HI - CAL_X_LO;
  localparam logic [COORD_W-1:0] SPAN_Y   = CAL_Y_HI - CAL_Y_LO;

  // floor reciprocals, quotient estimate is low by at most one
  localparam int RECIP_SHIFT = PROD_W;
  localparam int RECIP_W     = 13;
  localparam logic [RECIP_W-1:0] RECIP_X = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(SPAN_X));
  localparam logic [RECIP_W-1:0] RECIP_Y = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'(SPAN_Y));

  // register reset values
  localparam logic [ROT_W-1:0]   RST_ROTATION = '0;
  localparam logic [COORD_W-1:0] RST_WIDTH    = COORD_W'(240);
  localparam logic [COORD_W-1:0] RST_HEIGHT   = COORD_W'(320);
  localparam logic [TIMER_W-1:0] RST_PRESS    = TIMER_W'(50);
  localparam logic [TIMER_W-1:0] RST_RELEASE  = TIMER_W'(50);
  localparam logic [TIMER_W-1:0] RST_HOLD     = TIMER_W'(10);

  localparam logic EV_PRESS   = 1'b0;
  localparam logic EV_RELEASE = 1'b1;

  localparam logic [ROT_W-1:0] ROT_0 = 2'd0;
  localparam logic [ROT_W-1:0] ROT_1 = 2'd1;
  localparam logic [ROT_W-1:0] ROT_2 = 2'd2;
  localparam logic [ROT_W-1:0] ROT_3 = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROTATION = 3'd0,
    CFG_WIDTH    = 3'd1,
    CFG_HEIGHT   = 3'd2,
    CFG_PRESS    = 3'd3,
    CFG_RELEASE  = 3'd4,
    CFG_HOLD     = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESS   = 2'd1,
    PH_HELD    = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

  typedef struct packed {
    logic [ROT_W-1:0]   rotation;
    logic [COORD_W-1:0] width;
    logic [COORD_W-1:0] height;
    logic [TIMER_W-1:0] press_ticks;
    logic [TIMER_W-1:0] release_ticks;
    logic [TIMER_W-1:0] hold_ticks;
  } cfg_t;

  // one scaling lane: offset into the window, target size, which span
  typedef struct packed {
    logic [COORD_W-1:0] off;
    logic [COORD_W-1:0] size;
    logic               span_y;
  } lane_t;

  typedef struct packed {
    logic ld2;
    logic ld3;
  } stage_en_t;

endpackage

`default_nettype wire

[hw/rtl/tpr_in_if.sv]
// poll request channel: valid/ready handshake with one controller poll
// depends on tpr_pkg
`default_nettype none

interface tpr_in_if;
  logic                        valid;
  logic                        ready;
  logic                        pen_down;
  logic                        sample_valid;
  logic [tpr_pkg::COORD_W-1:0] raw_x;
  logic [tpr_pkg::COORD_W-1:0] raw_y;

  modport source (output valid, pen_down, sample_valid, raw_x, raw_y, input ready);
  modport sink   (input valid, pen_down, sample_valid, raw_x, raw_y, output ready);
endinterface

`default_nettype wire

[hw/rtl/tpr_out_if.sv]
// touch event channel: valid/ready handshake with one press or release event
// depends on tpr_pkg
`default_nettype none

interface tpr_out_if;
  logic                        valid;
  logic                        ready;
  logic                        event_kind;
  logic [tpr_pkg::COORD_W-1:0] event_x;
  logic [tpr_pkg::COORD_W-1:0] event_y;

  modport source (output valid, event_kind, event_x, event_y, input ready);
  modport sink   (input valid, event_kind, event_x, event_y, output ready);
endinterface

`default_nettype wire

[hw/rtl/tpr_cfg.sv]
// configuration register file written through a plain write port
// depends on tpr_pkg
`default_nettype none

module tpr_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           wen,
  input  wire logic [tpr_pkg::CFG_IDX_W-1:0]  idx,
  input  wire logic [tpr_pkg::CFG_DATA_W-1:0] data,
  output tpr_pkg::cfg_t                       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rotation      <= tpr_pkg::RST_ROTATION;
      cfg.width         <= tpr_pkg::RST_WIDTH;
      cfg.height        <= tpr_pkg::RST_HEIGHT;
      cfg.press_ticks   <= tpr_pkg::RST_PRESS;
      cfg.release_ticks <= tpr_pkg::RST_RELEASE;
      cfg.hold_ticks    <= tpr_pkg::RST_HOLD;
    end else if (wen) begin
      unique case (tpr_pkg::cfg_idx_t'(idx))
        tpr_pkg::CFG_ROTATION: cfg.rotation      <= data[tpr_pkg::ROT_W-1:0];
        tpr_pkg::CFG_WIDTH:    cfg.width         <= data[tpr_pkg::COORD_W-1:0];
        tpr_pkg::CFG_HEIGHT:   cfg.height        <= data[tpr_pkg::COORD_W-1:0];
        tpr_pkg::CFG_PRESS:    cfg.press_ticks   <= data[tpr_pkg::TIMER_W-1:0];
        tpr_pkg::CFG_RELEASE:  cfg.release_ticks <= data[tpr_pkg::TIMER_W-1:0];
        tpr_pkg::CFG_HOLD:     cfg.hold_ticks    <= data[tpr_pkg::TIMER_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tpr_ctl.sv]
// debounce phase machine, window clamp and rotation lane setup;
// registers the kind and lane operands of each event; depends on tpr_pkg
`default_nettype none

module tpr_ctl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire tpr_pkg::cfg_t               cfg,
  input  wire logic                        accept,
  input  wire logic                        pen_down,
  input  wire logic                        sample_valid,
  input  wire logic [tpr_pkg::COORD_W-1:0] raw_x,
  input  wire logic [tpr_pkg::COORD_W-1:0] raw_y,
  output logic                             fire,
  output logic                             kind,
  output tpr_pkg::lane_t                   lane_x,
  output tpr_pkg::lane_t                   lane_y
);

  tpr_pkg::phase_t              phase;
  tpr_pkg::phase_t              phase_next;
  logic [tpr_pkg::TIMER_W-1:0]  wait_counter;
  logic [tpr_pkg::TIMER_W-1:0]  wait_counter_next;
  logic [tpr_pkg::TIMER_W-1:0]  cnt_dec;
  logic                         kind_next;
  logic [tpr_pkg::COORD_W-1:0]  cx;
  logic [tpr_pkg::COORD_W-1:0]  cy;
  logic [tpr_pkg::COORD_W-1:0]  x_lo_off;
  logic [tpr_pkg::COORD_W-1:0]  x_hi_off;
  logic [tpr_pkg::COORD_W-1:0]  y_lo_off;
  logic [tpr_pkg::COORD_W-1:0]  y_hi_off;
  tpr_pkg::lane_t               lane_x_next;
  tpr_pkg::lane_t               lane_y_next;

  assign cnt_dec = (wait_counter != '0) ? wait_counter - 1'b1 : '0;

  // next state
  always_comb begin
    phase_next        = phase;
    wait_counter_next = wait_counter;
    if (phase == tpr_pkg::PH_IDLE) begin
      if (pen_down) begin
        phase_next        = tpr_pkg::PH_PRESS;
        wait_counter_next = cfg.press_ticks;
      end
    end else begin
      wait_counter_next = cnt_dec;
      if (cnt_dec == '0) begin
        unique case (phase)
          tpr_pkg::PH_PRESS: begin
            if (!pen_down) phase_next = tpr_pkg::PH_IDLE;
            else if (sample_valid) phase_next = tpr_pkg::PH_HELD;
          end
          tpr_pkg::PH_HELD: begin
            if (pen_down) begin
              wait_counter_next = cfg.hold_ticks;
            end else begin
              wait_counter_next = cfg.release_ticks;
              phase_next        = tpr_pkg::PH_RELEASE;
            end
          end
          tpr_pkg::PH_RELEASE: begin
            phase_next = pen_down ? tpr_pkg::PH_HELD : tpr_pkg::PH_IDLE;
          end
          default: ;
        endcase
      end
    end
  end

  // event decision
  always_comb begin
    fire      = 1'b0;
    kind_next = tpr_pkg::EV_PRESS;
    if (phase != tpr_pkg::PH_IDLE && cnt_dec == '0) begin
      unique case (phase)
        tpr_pkg::PH_PRESS: begin
          fire = pen_down && sample_valid;
        end
        tpr_pkg::PH_RELEASE: begin
          fire      = !pen_down;
          kind_next = tpr_pkg::EV_RELEASE;
        end
        default: ;
      endcase
    end
  end

  // clamp and rotation mapping
  always_comb begin
    if (raw_x < tpr_pkg::CAL_X_LO)      cx = tpr_pkg::CAL_X_LO;
    else if (raw_x > tpr_pkg::CAL_X_HI) cx = tpr_pkg::CAL_X_HI;
    else                                cx = raw_x;
    if (raw_y < tpr_pkg::CAL_Y_LO)      cy = tpr_pkg::CAL_Y_LO;
    else if (raw_y > tpr_pkg::CAL_Y_HI) cy = tpr_pkg::CAL_Y_HI;
    else                                cy = raw_y;
    x_lo_off = cx - tpr_pkg::CAL_X_LO;
    x_hi_off = tpr_pkg::CAL_X_HI - cx;
    y_lo_off = cy - tpr_pkg::CAL_Y_LO;
    y_hi_off = tpr_pkg::CAL_Y_HI - cy;
    lane_x_next.size = cfg.width;
    lane_y_next.size = cfg.height;
    case (cfg.rotation)
      tpr_pkg::ROT_0: begin
        lane_x_next.off = x_lo_off; lane_x_next.span_y = 1'b0;
        lane_y_next.off = y_lo_off; lane_y_next.span_y = 1'b1;
      end
      tpr_pkg::ROT_1: begin
        lane_x_next.off = y_lo_off; lane_x_next.span_y = 1'b1;
        lane_y_next.off = x_hi_off; lane_y_next.span_y = 1'b0;
      end
      tpr_pkg::ROT_2: begin
        lane_x_next.off = x_hi_off; lane_x_next.span_y = 1'b0;
        lane_y_next.off = y_hi_off; lane_y_next.span_y = 1'b1;
      end
      default: begin
        lane_x_next.off = y_hi_off; lane_x_next.span_y = 1'b1;
        lane_y_next.off = x_lo_off; lane_y_next.span_y = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= tpr_pkg::PH_IDLE;
      wait_counter <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      wait_counter <= wait_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && fire) begin
      kind   <= kind_next;
      lane_x <= lane_x_next;
      lane_y <= lane_y_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tpr_scale.sv]
// one scaling lane: offset times size, then exact division by the window
// span through a reciprocal multiply and one correction; depends on tpr_pkg
`default_nettype none

module tpr_scale (
  input  wire logic                         clk,
  input  wire tpr_pkg::lane_t               lane,
  input  wire tpr_pkg::stage_en_t           en,
  output logic [tpr_pkg::COORD_W-1:0]       q
);

  localparam int T_W = tpr_pkg::PROD_W + tpr_pkg::RECIP_W;

  logic [tpr_pkg::PROD_W-1:0]  p2;
  logic                        span_y2;
  logic [tpr_pkg::PROD_W-1:0]  p3;
  logic                        span_y3;
  logic [tpr_pkg::COORD_W-1:0] q0;
  logic [tpr_pkg::RECIP_W-1:0] recip;
  logic [T_W-1:0]              t;
  logic [tpr_pkg::COORD_W-1:0] span;
  logic [tpr_pkg::PROD_W-1:0]  qd;
  logic [tpr_pkg::PROD_W-1:0]  rem;

  assign recip = span_y2 ? tpr_pkg::RECIP_Y : tpr_pkg::RECIP_X;
  assign t     = T_W'(p2) * T_W'(recip);

  always_ff @(posedge clk) begin
    if (en.ld2) begin
      p2      <= tpr_pkg::PROD_W'(lane.off) * tpr_pkg::PROD_W'(lane.size);
      span_y2 <= lane.span_y;
    end
    if (en.ld3) begin
      p3      <= p2;
      span_y3 <= span_y2;
      q0      <= t[tpr_pkg::RECIP_SHIFT +: tpr_pkg::COORD_W];
    end
  end

  // estimate is low by at most one
  assign span = span_y3 ? tpr_pkg::SPAN_Y : tpr_pkg::SPAN_X;
  assign qd   = tpr_pkg::PROD_W'(q0) * tpr_pkg::PROD_W'(span);
  assign rem  = p3 - qd;
  assign q    = (rem >= tpr_pkg::PROD_W'(span)) ? q0 + 1'b1 : q0;

endmodule

`default_nettype wire

[hw/rtl/touch_press_release_debouncer.sv]
// touch press/release debouncer, top level: config registers, phase machine,
// two scaling lanes and the event output register
// depends on tpr_pkg, tpr_in_if, tpr_out_if, tpr_cfg, tpr_ctl, tpr_scale
//
// usage
//   poll: one request per controller tick (pen_down, sample_valid, raw_x/y).
//   touch: zero or one event per request, press (kind 0) or release (kind 1)
//   with screen coordinates; a release repeats the stored press point.
//   cfg: write enable, register index and data, taken at any enabled edge.
// timing
//   a request is taken every cycle while the pipeline has room; the phase
//   machine acts at the accept edge, and its event passes the operand,
//   product and estimate registers into the output register, which takes
//   the corrected quotient. requests that cause no event never enter the
//   pipeline. throughput is one request per cycle while there is room.
// reset
//   rst clears the phase machine, the pipeline valids and the stored press
//   point, and loads the register defaults (240 x 320, rotation 0).
// stall
//   when touch is not ready the event waits in the output register; stages
//   behind it keep filling, and poll.ready drops only once all are full.
`default_nettype none

module touch_press_release_debouncer (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_wen,
  input  wire logic [tpr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [tpr_pkg::CFG_DATA_W-1:0] cfg_data,
  tpr_in_if.sink                              poll,
  tpr_out_if.source                           touch
);

  tpr_pkg::cfg_t               cfg;
  tpr_pkg::lane_t              lane_x;
  tpr_pkg::lane_t              lane_y;
  tpr_pkg::stage_en_t          en;
  logic                        fire;
  logic                        kind1;
  logic                        kind2;
  logic                        kind3;
  logic                        vld1;
  logic                        vld2;
  logic                        vld3;
  logic                        out_vld;
  logic                        out_free;
  logic                        rdy1;
  logic                        rdy2;
  logic                        rdy3;
  logic                        accept;
  logic                        ld1;
  logic                        ld_out;
  logic [tpr_pkg::COORD_W-1:0] qx;
  logic [tpr_pkg::COORD_W-1:0] qy;
  logic [tpr_pkg::COORD_W-1:0] held_x;
  logic [tpr_pkg::COORD_W-1:0] held_y;
  logic                        out_kind;
  logic [tpr_pkg::COORD_W-1:0] out_x;
  logic [tpr_pkg::COORD_W-1:0] out_y;

  tpr_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .wen  (cfg_wen),
    .idx  (cfg_idx),
    .data (cfg_data),
    .cfg  (cfg)
  );

  tpr_ctl u_ctl (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (accept),
    .pen_down     (poll.pen_down),
    .sample_valid (poll.sample_valid),
    .raw_x        (poll.raw_x),
    .raw_y        (poll.raw_y),
    .fire         (fire),
    .kind         (kind1),
    .lane_x       (lane_x),
    .lane_y       (lane_y)
  );

  tpr_scale u_scale_x (
    .clk  (clk),
    .lane (lane_x),
    .en   (en),
    .q    (qx)
  );

  tpr_scale u_scale_y (
    .clk  (clk),
    .lane (lane_y),
    .en   (en),
    .q    (qy)
  );

  // pipeline handshake
  assign out_free   = !out_vld || touch.ready;
  assign ld_out     = vld3 && out_free;
  assign rdy3       = !vld3 || out_free;
  assign en.ld3     = vld2 && rdy3;
  assign rdy2       = !vld2 || rdy3;
  assign en.ld2     = vld1 && rdy2;
  assign rdy1       = !vld1 || rdy2;
  assign accept     = poll.valid && rdy1;
  assign ld1        = accept && fire;
  assign poll.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld1    <= 1'b0;
      vld2    <= 1'b0;
      vld3    <= 1'b0;
      out_vld <= 1'b0;
      held_x  <= '0;
      held_y  <= '0;
    end else begin
      vld1    <= ld1 || (vld1 && !en.ld2);
      vld2    <= en.ld2 || (vld2 && !en.ld3);
      vld3    <= en.ld3 || (vld3 && !ld_out);
      out_vld <= ld_out || (out_vld && !touch.ready);
      if (ld_out && kind3 == tpr_pkg::EV_PRESS) begin
        held_x <= qx;
        held_y <= qy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld2) kind2 <= kind1;
    if (en.ld3) kind3 <= kind2;
    if (ld_out) begin
      out_kind <= kind3;
      out_x    <= (kind3 == tpr_pkg::EV_RELEASE) ? held_x : qx;
      out_y    <= (kind3 == tpr_pkg::EV_RELEASE) ? held_y : qy;
    end
  end

  assign touch.valid      = out_vld;
  assign touch.event_kind = out_kind;
  assign touch.event_x    = out_x;
  assign touch.event_y    = out_y;

endmodule

`default_nettype wire

[test/touch_press_release_debouncer_test.sv]
`timescale 1ns / 100ps
// testbench for touch_press_release_debouncer: drives controller polls and register
// writes, predicts press/release events with a scoreboard class and checks every event
// depends on tpr_pkg, tpr_in_if, tpr_out_if and the debouncer top level

module touch_press_release_debouncer_test;
  import tpr_pkg::*;

  typedef struct packed {
    logic               pen;
    logic               sample;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } poll_t;

  typedef struct packed {
    logic               kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } touch_event_t;

  class touch_event_scoreboard;
    cfg_t               regs;
    phase_t             phase;
    logic [TIMER_W-1:0] wait_left;
    logic [COORD_W-1:0] held_x;
    logic [COORD_W-1:0] held_y;
    touch_event_t       events_due[$];
    int                 errors;

    function new();
      regs.rotation      = RST_ROTATION;
      regs.width         = RST_WIDTH;
      regs.height        = RST_HEIGHT;
      regs.press_ticks   = RST_PRESS;
      regs.release_ticks = RST_RELEASE;
      regs.hold_ticks    = RST_HOLD;
      phase     = PH_IDLE;
      wait_left = '0;
      held_x    = '0;
      held_y    = '0;
      errors    = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_ROTATION: regs.rotation      = v[ROT_W-1:0];
        CFG_WIDTH:    regs.width         = v[COORD_W-1:0];
        CFG_HEIGHT:   regs.height        = v[COORD_W-1:0];
        CFG_PRESS:    regs.press_ticks   = v[TIMER_W-1:0];
        CFG_RELEASE:  regs.release_ticks = v[TIMER_W-1:0];
        CFG_HOLD:     regs.hold_ticks    = v[TIMER_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [COORD_W-1:0] to_pixels(logic [COORD_W-1:0] off, logic [COORD_W-1:0] span,
                                           logic [COORD_W-1:0] size);
      longint unsigned prod;
      prod = 64'(off) * 64'(size);
      return COORD_W'(prod / 64'(span));
    endfunction

    function void place_point(logic [COORD_W-1:0] rx, logic [COORD_W-1:0] ry);
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      cx = rx < CAL_X_LO ? CAL_X_LO : (rx > CAL_X_HI ? CAL_X_HI : rx);
      cy = ry < CAL_Y_LO ? CAL_Y_LO : (ry > CAL_Y_HI ? CAL_Y_HI : ry);
      case (regs.rotation)
        ROT_0: begin
          held_x = to_pixels(cx - CAL_X_LO, SPAN_X, regs.width);
          held_y = to_pixels(cy - CAL_Y_LO, SPAN_Y, regs.height);
        end
        ROT_1: begin
          held_x = to_pixels(cy - CAL_Y_LO, SPAN_Y, regs.width);
          held_y = to_pixels(CAL_X_HI - cx, SPAN_X, regs.height);
        end
        ROT_2: begin
          held_x = to_pixels(CAL_X_HI - cx, SPAN_X, regs.width);
          held_y = to_pixels(CAL_Y_HI - cy, SPAN_Y, regs.height);
        end
        default: begin
          held_x = to_pixels(CAL_Y_HI - cy, SPAN_Y, regs.width);
          held_y = to_pixels(cx - CAL_X_LO, SPAN_X, regs.height);
        end
      endcase
    endfunction

    function void note_poll(poll_t p);
      if (phase == PH_IDLE) begin
        if (p.pen) begin
          wait_left = regs.press_ticks;
          phase     = PH_PRESS;
        end
        return;
      end
      if (wait_left != 0) wait_left--;
      if (wait_left != 0) return;
      case (phase)
        PH_PRESS: begin
          if (!p.pen) begin
            phase = PH_IDLE;
          end else if (p.sample) begin
            place_point(p.x, p.y);
            phase = PH_HELD;
            events_due.push_back('{EV_PRESS, held_x, held_y});
          end
        end
        PH_HELD: begin
          if (p.pen) begin
            wait_left = regs.hold_ticks;
          end else begin
            wait_left = regs.release_ticks;
            phase     = PH_RELEASE;
          end
        end
        default: begin
          if (p.pen) begin
            phase = PH_HELD;
          end else begin
            phase = PH_IDLE;
            events_due.push_back('{EV_RELEASE, held_x, held_y});
          end
        end
      endcase
    endfunction

    function void check_event(logic kind, logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
      touch_event_t want;
      if (events_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected event: kind %0d x %0d y %0d", kind, x, y);
        return;
      end
      want = events_due.pop_front();
      if (want.kind !== kind || want.x !== x || want.y !== y) begin
        errors++;
        if (errors <= 10)
          $display("event mismatch: expected kind %0d x %0d y %0d, got kind %0d x %0d y %0d",
                   want.kind, want.x, want.y, kind, x, y);
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_wen;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  tpr_in_if  poll();
  tpr_out_if touch();

  touch_press_release_debouncer dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .poll     (poll),
    .touch    (touch)
  );

  touch_event_scoreboard sb = new();
  int idle_pct;
  int stall_pct;
  int polls_sent;

  int unsigned ph_rot[8]     = '{0, 1, 2, 3, 3, 1, 0, 2};
  int unsigned ph_width[8]   = '{240, 4095, 1, 0, 800, 0, 4095, 240};
  int unsigned ph_height[8]  = '{320, 4095, 1, 0, 480, 4095, 1, 320};
  int unsigned ph_press[8]   = '{3, 1, 5, 0, 7, 2, 130, 3};
  int unsigned ph_release[8] = '{3, 1, 4, 0, 2, 6, 120, 3};
  int unsigned ph_hold[8]    = '{2, 1, 3, 0, 5, 1, 100, 2};

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic poll_t make_poll(logic pen, logic sample, int unsigned x, int unsigned y);
    poll_t p;
    p.pen    = pen;
    p.sample = sample;
    p.x      = COORD_W'(x);
    p.y      = COORD_W'(y);
    return p;
  endfunction

  function automatic int unsigned rand_coord();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? 4095 : 0;
    return $urandom_range(4095);
  endfunction

  task automatic send_poll(input poll_t p);
    while ($urandom_range(99) < idle_pct) begin
      poll.valid <= 1'b0;
      @(posedge clk);
    end
    poll.valid        <= 1'b1;
    poll.pen_down     <= p.pen;
    poll.sample_valid <= p.sample;
    poll.raw_x        <= p.x;
    poll.raw_y        <= p.y;
    @(posedge clk);
    while (!poll.ready) @(posedge clk);
    sb.note_poll(p);
    polls_sent++;
  endtask

  task automatic send_run(int n, logic pen, int sample_pct);
    repeat (n)
      send_poll(make_poll(pen, $urandom_range(99) < sample_pct, rand_coord(), rand_coord()));
  endtask

  task automatic write_reg(cfg_idx_t idx, int unsigned v);
    cfg_wen  <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= CFG_DATA_W'(v);
    sb.set_reg(idx, CFG_DATA_W'(v));
    @(posedge clk);
  endtask

  task automatic write_regs(int unsigned rot, int unsigned w, int unsigned h,
                            int unsigned pr, int unsigned rl, int unsigned hd);
    write_reg(CFG_ROTATION, rot);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_PRESS, pr);
    write_reg(CFG_RELEASE, rl);
    write_reg(CFG_HOLD, hd);
    cfg_wen <= 1'b0;
  endtask

  // let the pipeline empty before touching the registers
  task automatic drain();
    int waited;
    waited = 0;
    poll.valid <= 1'b0;
    while (sb.events_due.size() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
  endtask

  task automatic run_gesture();
    int press_n;
    int rel_n;
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 6))
        send_poll(make_poll(1'($urandom_range(1)), 1'($urandom_range(1)), rand_coord(),
                            rand_coord()));
    end
    press_n = sb.regs.press_ticks + 1 + $urandom_range(2);
    rel_n   = sb.regs.release_ticks + 1 + $urandom_range(2);
    if ($urandom_range(99) < 10) begin
      send_run($urandom_range(1, press_n), 1'b1, 50);
      send_run($urandom_range(1, 3), 1'b0, 50);
      return;
    end
    send_run(press_n, 1'b1, 80);
    send_run($urandom_range(1, sb.regs.hold_ticks + 4), 1'b1, 50);
    if ($urandom_range(99) < 20) begin
      send_run($urandom_range(1, sb.regs.release_ticks + 1), 1'b0, 50);
      send_run($urandom_range(1, sb.regs.hold_ticks + 2), 1'b1, 50);
    end
    send_run(rel_n, 1'b0, 50);
  endtask

  initial begin
    touch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && touch.valid && touch.ready)
        sb.check_event(touch.event_kind, touch.event_x, touch.event_y);
      touch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    poll_t directed[$];
    int    start;
    idle_pct          = 0;
    stall_pct         = 0;
    polls_sent        = 0;
    rst               <= 1'b1;
    cfg_wen           <= 1'b0;
    cfg_idx           <= CFG_ROTATION;
    cfg_data          <= '0;
    poll.valid        <= 1'b0;
    poll.pen_down     <= 1'b0;
    poll.sample_valid <= 1'b0;
    poll.raw_x        <= '0;
    poll.raw_y        <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_regs(0, 240, 320, 2, 2, 1);
    // press held back until a sample arrives, held resample, return to held, bounce, clamps
    directed = '{make_poll(1'b1, 1'b0, 0, 0), make_poll(1'b1, 1'b0, 0, 0),
                 make_poll(1'b1, 1'b0, 0, 0),
                 make_poll(1'b1, 1'b1, 0, 0), make_poll(1'b1, 1'b1, 4095, 4095),
                 make_poll(1'b0, 1'b0, 0, 0), make_poll(1'b1, 1'b0, 0, 0),
                 make_poll(1'b1, 1'b0, 0, 0),
                 make_poll(1'b0, 1'b1, 4095, 0), make_poll(1'b0, 1'b0, 0, 0),
                 make_poll(1'b0, 1'b0, 0, 0),
                 make_poll(1'b1, 1'b1, 0, 4095), make_poll(1'b0, 1'b1, 0, 0),
                 make_poll(1'b0, 1'b0, 0, 0),
                 make_poll(1'b1, 1'b0, 0, 0), make_poll(1'b1, 1'b0, 0, 0),
                 make_poll(1'b1, 1'b1, 4095, 4095),
                 make_poll(1'b0, 1'b0, 0, 0), make_poll(1'b0, 1'b0, 0, 0),
                 make_poll(1'b0, 1'b0, 0, 0),
                 make_poll(1'b1, 1'b1, 2060, 1945), make_poll(1'b1, 1'b1, 100, 4000),
                 make_poll(1'b1, 1'b1, 100, 4000), make_poll(1'b0, 1'b0, 0, 0),
                 make_poll(1'b0, 1'b0, 0, 0)};
    foreach (directed[i]) send_poll(directed[i]);
    send_run(3, 1'b0, 50);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 58; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 58; end
        default: begin idle_pct = 11; stall_pct = 11; end
      endcase
      if (p == 7)
        write_regs($urandom_range(3), $urandom_range(1, 4095), $urandom_range(1, 4095),
                   $urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8));
      else
        write_regs(ph_rot[p], ph_width[p], ph_height[p], ph_press[p], ph_release[p],
                   ph_hold[p]);
      start = polls_sent;
      do run_gesture(); while (polls_sent - start < (p == 6 ? 0 : 170));
      drain();
    end

    repeat (16) @(posedge clk);
    if (sb.errors == 0 && sb.events_due.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
